// ===== rtl/core/mahd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mahd_pkg
// Constants, lookup tables and types for the MPEG audio header decoder.
// ----------------------------------------------------------------------------
package mahd_pkg;

	// sync and field masks
	localparam logic [7:0] SYNC_BYTE     = 8'hff;
	localparam logic [7:0] BE_SYNC_MASK  = 8'he0;
	localparam logic [7:0] VER_MASK      = 8'h18;
	localparam logic [7:0] VER_RESERVED  = 8'h08;
	localparam logic [7:0] LAYER_MASK    = 8'h06;
	localparam logic [7:0] BRI_MASK      = 8'hf0;
	localparam logic [7:0] SFI_MASK      = 8'h0c;
	localparam logic [7:0] LE_SYNC_MASK  = 8'hf0;

	// decoded codes
	localparam logic [1:0] VER_MPEG1     = 2'd0;
	localparam logic [1:0] VER_MPEG2     = 2'd1;
	localparam logic [1:0] LAYER_I       = 2'd0;
	localparam logic [1:0] LAYER_III     = 2'd2;
	localparam logic [3:0] BRI_LAST      = 4'd14;
	localparam logic [1:0] SFI_LAST      = 2'd2;
	localparam logic [1:0] CHMODE_SINGLE = 2'd3;

	localparam logic [10:0] SPF_LAYER_I  = 11'd384;
	localparam logic [10:0] SPF_OTHER    = 11'd1152;

	localparam logic [3:0] SPDIF_MPEG1_L1  = 4'h4;
	localparam logic [3:0] SPDIF_MPEG1_L23 = 4'h5;
	localparam logic [3:0] SPDIF_MPEG2_L1  = 4'h8;
	localparam logic [3:0] SPDIF_MPEG2_L23 = 4'h9;
	localparam logic [3:0] SPDIF_NONE      = 4'h0;

	// widths of the frame size datapath
	localparam int NUM_W   = 26;                // kbps * slots * 1000
	localparam int RECIP_W = 14;                // floor(2^NUM_W / rate)
	localparam int QUOT_W  = 12;
	localparam int PROD_W  = NUM_W + RECIP_W;

	// bitrate in kbit/s by [version][layer][bitrate index]
	localparam logic [8:0] KBPS_TAB [4][3][15] = '{
		'{ '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
		     9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448},
		   '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		     9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384},
		   '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
		     9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320} },
		'{ '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		     9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256},
		   '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
		     9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160},
		   '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
		     9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160} },
		'{default: '{default: 9'd0}},
		'{ '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		     9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256},
		   '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
		     9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160},
		   '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
		     9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160} }
	};

	// sample rate in Hz by [version][rate index]
	localparam logic [15:0] RATE_TAB [4][3] = '{
		'{16'd44100, 16'd48000, 16'd32000},
		'{16'd22050, 16'd24000, 16'd16000},
		'{16'd0,     16'd0,     16'd0},
		'{16'd11025, 16'd12000, 16'd8000}
	};

	// slots per frame times 1000 by [version][layer]
	localparam logic [17:0] SLOT_K_TAB [4][3] = '{
		'{18'd12000, 18'd144000, 18'd144000},
		'{18'd12000, 18'd144000, 18'd72000},
		'{18'd0,     18'd0,      18'd0},
		'{18'd12000, 18'd144000, 18'd72000}
	};

	localparam logic [63:0] RECIP_ONE = 64'd1 << NUM_W;

	// reciprocal of the sample rate, scaled by 2^NUM_W and rounded down
	localparam logic [RECIP_W-1:0] RECIP_TAB [4][3] = '{
		'{RECIP_W'(RECIP_ONE / 64'd44100), RECIP_W'(RECIP_ONE / 64'd48000),
		  RECIP_W'(RECIP_ONE / 64'd32000)},
		'{RECIP_W'(RECIP_ONE / 64'd22050), RECIP_W'(RECIP_ONE / 64'd24000),
		  RECIP_W'(RECIP_ONE / 64'd16000)},
		'{RECIP_W'(0), RECIP_W'(0), RECIP_W'(0)},
		'{RECIP_W'(RECIP_ONE / 64'd11025), RECIP_W'(RECIP_ONE / 64'd12000),
		  RECIP_W'(RECIP_ONE / 64'd8000)}
	};

	// decoded header fields carried down the pipeline
	typedef struct packed {
		logic        vres;
		logic        kind;
		logic [1:0]  ver;
		logic [1:0]  lay;
		logic [8:0]  kbps;
		logic [15:0] rate;
		logic [10:0] spf;
		logic        mono;
		logic [3:0]  spdif;
		logic        pad;
		logic        lay1;
	} hdr_t;

endpackage

// ===== rtl/core/mpeg_audio_header_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpeg_audio_header_decoder
// Checks four candidate bytes for an MPEG audio frame header and decodes it.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_ready with byte0..byte3, the candidate header
//   bytes in stream order; one transfer per candidate
//   output channel: out_valid/out_ready with the decoded fields; one transfer
//   per input transfer, in order; valid_res low means no sync and all other
//   fields are zero
//   pipeline: an input transfer passes through five register stages (decode,
//   numerator multiply, reciprocal multiply, remainder multiply, correction
//   and output register) before out_valid rises
//   throughput: one header per cycle when the output is not stalled; the frame
//   size division is done as a multiply by a tabled reciprocal plus a one-step
//   correction, so no stage iterates
//   reset: arst_n clears every stage valid bit; the data registers are not reset
//   stall: when out_ready is low, stages ahead of a bubble keep filling; once
//   all five are full, in_ready drops and every stage holds its data
// ----------------------------------------------------------------------------
module mpeg_audio_header_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte0,
	input  logic [7:0]  byte1,
	input  logic [7:0]  byte2,
	input  logic [7:0]  byte3,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        valid_res,
	output logic        stream_kind,
	output logic [1:0]  mpeg_version,
	output logic [1:0]  layer_number,
	output logic [8:0]  bitrate_kbps,
	output logic [15:0] rate_hz,
	output logic [11:0] frame_bytes,
	output logic [10:0] samples_per_frame,
	output logic        is_mono,
	output logic [3:0]  burst_type
);

	// ------------------------------------------------------------------
	// pipeline flow control: a stage loads when it is empty or its
	// successor moves
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv1, adv2, adv3, adv4, adv5;

	assign adv5     = !v_s5 || out_ready;
	assign adv4     = !v_s4 || adv5;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: sync check, field extraction and table lookups
	// ------------------------------------------------------------------
	logic       be_ok, le_ok, ok;
	logic [7:0] hi, mid, lo;
	logic [1:0] ver, lay, sfi, mode;
	logic [3:0] bri;
	mahd_pkg::hdr_t hdr_d;
	logic [17:0] slot_k_d;
	logic [mahd_pkg::RECIP_W-1:0] recip_d;

	// big-endian form: 0xff then 111x with a legal version, layer, rates
	assign be_ok = (byte0 == mahd_pkg::SYNC_BYTE)
		&& ((byte1 & mahd_pkg::BE_SYNC_MASK) == mahd_pkg::BE_SYNC_MASK)
		&& ((byte1 & mahd_pkg::VER_MASK) != mahd_pkg::VER_RESERVED)
		&& ((byte1 & mahd_pkg::LAYER_MASK) != 8'h00)
		&& ((byte2 & mahd_pkg::BRI_MASK) != mahd_pkg::BRI_MASK)
		&& ((byte2 & mahd_pkg::SFI_MASK) != mahd_pkg::SFI_MASK);

	// little-endian 16-bit form: halves swapped, no MPEG2.5
	assign le_ok = (byte1 == mahd_pkg::SYNC_BYTE)
		&& ((byte0 & mahd_pkg::LE_SYNC_MASK) == mahd_pkg::LE_SYNC_MASK)
		&& ((byte0 & mahd_pkg::LAYER_MASK) != 8'h00)
		&& ((byte3 & mahd_pkg::BRI_MASK) != mahd_pkg::BRI_MASK)
		&& ((byte3 & mahd_pkg::SFI_MASK) != mahd_pkg::SFI_MASK);

	assign ok = be_ok || le_ok;

	always_comb begin
		// big-endian wins when both forms match
		if (be_ok) begin
			hi  = byte1;
			mid = byte2;
			lo  = byte3;
		end else begin
			hi  = byte0;
			mid = byte3;
			lo  = byte2;
		end

		// version and layer codes count down in the header
		ver  = ~hi[4:3];
		lay  = (~hi[2:1] == 2'd3) ? mahd_pkg::LAYER_III : ~hi[2:1];
		bri  = (mid[7:4] > mahd_pkg::BRI_LAST) ? mahd_pkg::BRI_LAST : mid[7:4];
		sfi  = (mid[3:2] > mahd_pkg::SFI_LAST) ? mahd_pkg::SFI_LAST : mid[3:2];
		mode = lo[7:6];

		hdr_d       = '0;
		slot_k_d    = '0;
		recip_d     = '0;
		if (ok) begin
			hdr_d.vres  = 1'b1;
			hdr_d.kind  = !be_ok;
			hdr_d.ver   = ver;
			hdr_d.lay   = lay;
			hdr_d.kbps  = mahd_pkg::KBPS_TAB[ver][lay][bri];
			hdr_d.rate  = mahd_pkg::RATE_TAB[ver][sfi];
			hdr_d.spf   = (lay == mahd_pkg::LAYER_I) ? mahd_pkg::SPF_LAYER_I
				: mahd_pkg::SPF_OTHER;
			hdr_d.mono  = (mode == mahd_pkg::CHMODE_SINGLE);
			hdr_d.pad   = mid[1];
			hdr_d.lay1  = (lay == mahd_pkg::LAYER_I);
			case (ver)
				mahd_pkg::VER_MPEG1: begin
					hdr_d.spdif = (lay == mahd_pkg::LAYER_I) ? mahd_pkg::SPDIF_MPEG1_L1
						: mahd_pkg::SPDIF_MPEG1_L23;
				end
				mahd_pkg::VER_MPEG2: begin
					hdr_d.spdif = (lay == mahd_pkg::LAYER_I) ? mahd_pkg::SPDIF_MPEG2_L1
						: mahd_pkg::SPDIF_MPEG2_L23;
				end
				default: begin
					hdr_d.spdif = mahd_pkg::SPDIF_NONE;
				end
			endcase
			slot_k_d = mahd_pkg::SLOT_K_TAB[ver][lay];
			recip_d  = mahd_pkg::RECIP_TAB[ver][sfi];
		end
	end

	mahd_pkg::hdr_t hdr_s1, hdr_s2, hdr_s3, hdr_s4, hdr_s5;
	logic [17:0] slot_k_s1;
	logic [mahd_pkg::RECIP_W-1:0] recip_s1, recip_s2;

	always_ff @(posedge clk) begin
		if (adv1) begin
			hdr_s1    <= hdr_d;
			slot_k_s1 <= slot_k_d;
			recip_s1  <= recip_d;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: numerator kbps * slots * 1000
	// ------------------------------------------------------------------
	logic [26:0] num_full;
	logic [mahd_pkg::NUM_W-1:0] num_s2, num_s3, num_s4;

	assign num_full = 27'(hdr_s1.kbps) * 27'(slot_k_s1);

	always_ff @(posedge clk) begin
		if (adv2) begin
			hdr_s2   <= hdr_s1;
			num_s2   <= num_full[mahd_pkg::NUM_W-1:0];
			recip_s2 <= recip_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: quotient estimate, low by at most one
	// ------------------------------------------------------------------
	logic [mahd_pkg::PROD_W-1:0] qprod;
	logic [mahd_pkg::QUOT_W-1:0] q_s3, q_s4;

	assign qprod = mahd_pkg::PROD_W'(num_s2) * mahd_pkg::PROD_W'(recip_s2);

	always_ff @(posedge clk) begin
		if (adv3) begin
			hdr_s3 <= hdr_s2;
			num_s3 <= num_s2;
			q_s3   <= qprod[mahd_pkg::NUM_W +: mahd_pkg::QUOT_W];
		end
	end

	// ------------------------------------------------------------------
	// stage 4: back-multiply the estimate by the rate
	// ------------------------------------------------------------------
	logic [27:0] back_full;
	logic [mahd_pkg::NUM_W-1:0] back_s4;

	assign back_full = 28'(q_s3) * 28'(hdr_s3.rate);

	always_ff @(posedge clk) begin
		if (adv4) begin
			hdr_s4  <= hdr_s3;
			num_s4  <= num_s3;
			q_s4    <= q_s3;
			back_s4 <= back_full[mahd_pkg::NUM_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// stage 5: remainder correction, padding, layer I scaling
	// ------------------------------------------------------------------
	logic [mahd_pkg::NUM_W-1:0]  rem;
	logic [mahd_pkg::QUOT_W-1:0] quot, slots_sum, size_d;
	logic [11:0] size_s5;

	always_comb begin
		rem       = num_s4 - back_s4;
		quot      = q_s4 + ((rem >= mahd_pkg::NUM_W'(hdr_s4.rate))
			? mahd_pkg::QUOT_W'(1) : mahd_pkg::QUOT_W'(0));
		slots_sum = quot + mahd_pkg::QUOT_W'(hdr_s4.pad);
		// free format and no-sync give no size
		if (hdr_s4.kbps == 9'd0 || hdr_s4.rate == 16'd0) begin
			size_d = '0;
		end else if (hdr_s4.lay1) begin
			size_d = {slots_sum[mahd_pkg::QUOT_W-3:0], 2'b00};
		end else begin
			size_d = slots_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			hdr_s5  <= hdr_s4;
			size_s5 <= size_d;
		end
	end

	// ------------------------------------------------------------------
	// outputs
	// ------------------------------------------------------------------
	assign out_valid         = v_s5;
	assign valid_res         = hdr_s5.vres;
	assign stream_kind       = hdr_s5.kind;
	assign mpeg_version      = hdr_s5.ver;
	assign layer_number      = hdr_s5.lay;
	assign bitrate_kbps      = hdr_s5.kbps;
	assign rate_hz           = hdr_s5.rate;
	assign frame_bytes       = size_s5;
	assign samples_per_frame = hdr_s5.spf;
	assign is_mono           = hdr_s5.mono;
	assign burst_type        = hdr_s5.spdif;

endmodule

// ===== bench/tb_mpeg_audio_header_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mpeg_audio_header_decoder
// Self-checking bench for the MPEG audio header decoder. A short table of
// hand-picked candidates (no sync, each rejected code, both sync forms, every
// version and layer, free format, field extremes) is followed by random
// candidates, mostly well-formed headers with random content plus broken
// headers and raw noise. Each accepted candidate that is not pinned is decoded
// by a local model; the decoded fields are compared with every output transfer
// in order. Both channels idle at random, and the result side holds off once
// for a long stretch so that the pipeline fills and back-pressures its input.
// ----------------------------------------------------------------------------
module tb_mpeg_audio_header_decoder;

	localparam int N_RANDOM     = 750;
	localparam int HOLD_CYCLES  = 64;     // long result-side hold-off
	localparam int HOLD_AT      = 200;    // results taken before the hold-off
	localparam int DRAIN_CYCLES = 20;     // pipeline is five stages deep
	localparam int LIMIT_NS     = 2_000_000;
	localparam int MAX_REPORTS  = 10;

	// raw codes as they sit in the header
	localparam logic [1:0] RAW_VER_RES   = 2'b01;
	localparam logic [1:0] RAW_LAY_NONE  = 2'b00;
	localparam logic [3:0] RAW_BRI_BAD   = 4'hf;
	localparam logic [1:0] RAW_SFI_BAD   = 2'b11;

	// bitrate in kbit/s, mpeg1 by layer, lsf (mpeg2 and 2.5) by layer I / II-III
	localparam int MPEG1_KBPS [3][15] = '{
		'{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448},
		'{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384},
		'{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320}
	};
	localparam int LSF_KBPS [2][15] = '{
		'{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256},
		'{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160}
	};
	// mpeg1 rates; mpeg2 halves them, mpeg2.5 quarters them
	localparam int MPEG1_RATE [3] = '{44100, 48000, 32000};

	typedef struct packed {
		logic        valid_res;
		logic        stream_kind;
		logic [1:0]  mpeg_version;
		logic [1:0]  layer_number;
		logic [8:0]  bitrate_kbps;
		logic [15:0] rate_hz;
		logic [11:0] frame_bytes;
		logic [10:0] samples_per_frame;
		logic        is_mono;
		logic [3:0]  burst_type;
	} hdr_fields_t;

	// one directed candidate; pinned rows carry a hand-typed decode
	typedef struct packed {
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [7:0]  b3;
		logic        pinned;
		hdr_fields_t want;
	} stim_row_t;

	localparam hdr_fields_t NO_SYNC = '0;
	// ff fb 90 64: mpeg1 layer III, 128 kbit/s, 44.1 kHz, joint stereo
	localparam hdr_fields_t MP1_L3_128K = '{1'b1, 1'b0, mahd_pkg::VER_MPEG1,
		mahd_pkg::LAYER_III, 9'd128, 16'd44100, 12'd417, mahd_pkg::SPF_OTHER, 1'b0,
		mahd_pkg::SPDIF_MPEG1_L23};

	localparam int N_DIRECTED = 25;
	localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{8'h00, 8'h00, 8'h00, 8'h00, 1'b1, NO_SYNC},      // all bits low
		'{8'hff, 8'hff, 8'hff, 8'hff, 1'b1, NO_SYNC},      // all bits high
		'{8'hff, 8'hfb, 8'h90, 8'h64, 1'b1, MP1_L3_128K},  // common mp3 header
		'{8'hff, 8'he9, 8'h90, 8'h00, 1'b1, NO_SYNC},      // reserved version
		'{8'hff, 8'hf9, 8'h90, 8'h00, 1'b1, NO_SYNC},      // layer code zero
		'{8'hff, 8'hfb, 8'hf0, 8'h00, 1'b1, NO_SYNC},      // bitrate index 15
		'{8'hff, 8'hfb, 8'h9c, 8'h00, 1'b1, NO_SYNC},      // rate index 3
		'{8'hfb, 8'hff, 8'h64, 8'h90, 1'b0, NO_SYNC},      // little-endian mpeg1
		'{8'he3, 8'hff, 8'h64, 8'h90, 1'b1, NO_SYNC},      // no mpeg2.5 when swapped
		'{8'hff, 8'hff, 8'h10, 8'h10, 1'b0, NO_SYNC},      // both forms, big wins
		'{8'hff, 8'hff, 8'hf0, 8'h10, 1'b0, NO_SYNC},      // only swapped form
		'{8'hff, 8'hfb, 8'h00, 8'h00, 1'b0, NO_SYNC},      // free format
		'{8'hff, 8'hf7, 8'he8, 8'hc0, 1'b0, NO_SYNC},      // mpeg2 layer I
		'{8'hff, 8'he3, 8'hea, 8'hc0, 1'b0, NO_SYNC},      // mpeg2.5 layer III
		'{8'hff, 8'he5, 8'he6, 8'h00, 1'b0, NO_SYNC},      // mpeg2.5 layer II
		'{8'hff, 8'hfd, 8'he6, 8'hff, 1'b0, NO_SYNC},      // mpeg1 layer II, mono
		'{8'hff, 8'hff, 8'hea, 8'hc0, 1'b0, NO_SYNC},      // mpeg1 layer I, top rate
		'{8'hff, 8'hf5, 8'h12, 8'h40, 1'b0, NO_SYNC},      // mpeg2 layer II
		'{8'hff, 8'hf3, 8'h54, 8'h80, 1'b0, NO_SYNC},      // mpeg2 layer III
		'{8'hff, 8'he7, 8'h08, 8'h00, 1'b0, NO_SYNC},      // mpeg2.5 layer I, free
		'{8'hf7, 8'hff, 8'hc0, 8'he8, 1'b0, NO_SYNC},      // little-endian mpeg2
		'{8'hf9, 8'hff, 8'h00, 8'h90, 1'b1, NO_SYNC},      // swapped, layer zero
		'{8'hfb, 8'hff, 8'h00, 8'hf0, 1'b1, NO_SYNC},      // swapped, bitrate 15
		'{8'hfb, 8'hff, 8'h00, 8'h9c, 1'b1, NO_SYNC},      // swapped, rate 3
		'{8'hfe, 8'h7f, 8'h01, 8'h80, 1'b1, NO_SYNC}       // near-sync noise
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  byte0;
	logic [7:0]  byte1;
	logic [7:0]  byte2;
	logic [7:0]  byte3;
	logic        out_valid;
	logic        out_ready;
	logic        valid_res;
	logic        stream_kind;
	logic [1:0]  mpeg_version;
	logic [1:0]  layer_number;
	logic [8:0]  bitrate_kbps;
	logic [15:0] rate_hz;
	logic [11:0] frame_bytes;
	logic [10:0] samples_per_frame;
	logic        is_mono;
	logic [3:0]  burst_type;

	hdr_fields_t pending_hdrs [$];   // decodes awaiting their output transfer
	int          n_fail = 0;

	mpeg_audio_header_decoder dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.byte0             (byte0),
		.byte1             (byte1),
		.byte2             (byte2),
		.byte3             (byte3),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.valid_res         (valid_res),
		.stream_kind       (stream_kind),
		.mpeg_version      (mpeg_version),
		.layer_number      (layer_number),
		.bitrate_kbps      (bitrate_kbps),
		.rate_hz           (rate_hz),
		.frame_bytes       (frame_bytes),
		.samples_per_frame (samples_per_frame),
		.is_mono           (is_mono),
		.burst_type        (burst_type)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// decode one candidate the way the block should
	function automatic hdr_fields_t decode_header(input logic [7:0] b0, b1, b2, b3);
		hdr_fields_t r;
		logic [7:0]  hi;
		logic [7:0]  mid;
		logic [7:0]  lo;
		logic [1:0]  ver;
		logic [1:0]  lay;
		logic [1:0]  sfi;
		logic [3:0]  bri;
		bit          be_ok;
		bit          le_ok;
		int unsigned kbps;
		int unsigned rate;
		int unsigned slots;
		int unsigned size;
		r = NO_SYNC;
		be_ok = b0 == mahd_pkg::SYNC_BYTE && b1[7:5] == 3'b111 && b1[4:3] != RAW_VER_RES &&
			b1[2:1] != RAW_LAY_NONE && b2[7:4] != RAW_BRI_BAD && b2[3:2] != RAW_SFI_BAD;
		le_ok = b1 == mahd_pkg::SYNC_BYTE && b0[7:4] == 4'hf && b0[2:1] != RAW_LAY_NONE &&
			b3[7:4] != RAW_BRI_BAD && b3[3:2] != RAW_SFI_BAD;
		// big-endian form has priority
		if (be_ok) begin
			hi = b1; mid = b2; lo = b3;
			r.stream_kind = 1'b0;
		end else if (le_ok) begin
			hi = b0; mid = b3; lo = b2;
			r.stream_kind = 1'b1;
		end else begin
			return r;
		end
		ver = 2'd3 - hi[4:3];
		lay = 2'd3 - hi[2:1];
		bri = mid[7:4];
		sfi = mid[3:2];
		if (ver == mahd_pkg::VER_MPEG1)
			kbps = MPEG1_KBPS[lay][bri];
		else
			kbps = LSF_KBPS[(lay == mahd_pkg::LAYER_I) ? 0 : 1][bri];
		case (ver)
			mahd_pkg::VER_MPEG1: rate = MPEG1_RATE[sfi];
			mahd_pkg::VER_MPEG2: rate = MPEG1_RATE[sfi] / 2;
			default:             rate = MPEG1_RATE[sfi] / 4;
		endcase
		if (lay == mahd_pkg::LAYER_I)
			slots = 12;
		else if (lay == mahd_pkg::LAYER_III && ver != mahd_pkg::VER_MPEG1)
			slots = 72;
		else
			slots = 144;
		size = (kbps != 0) ? kbps * 1000 * slots / rate + 32'(mid[1]) : 0;
		if (lay == mahd_pkg::LAYER_I)
			size = size * 4;
		r.valid_res         = 1'b1;
		r.mpeg_version      = ver;
		r.layer_number      = lay;
		r.bitrate_kbps      = kbps[8:0];
		r.rate_hz           = rate[15:0];
		r.frame_bytes       = size[11:0];
		r.samples_per_frame = (lay == mahd_pkg::LAYER_I) ? mahd_pkg::SPF_LAYER_I
			: mahd_pkg::SPF_OTHER;
		r.is_mono           = lo[7:6] == mahd_pkg::CHMODE_SINGLE;
		case (ver)
			mahd_pkg::VER_MPEG1: r.burst_type = (lay == mahd_pkg::LAYER_I)
				? mahd_pkg::SPDIF_MPEG1_L1 : mahd_pkg::SPDIF_MPEG1_L23;
			mahd_pkg::VER_MPEG2: r.burst_type = (lay == mahd_pkg::LAYER_I)
				? mahd_pkg::SPDIF_MPEG2_L1 : mahd_pkg::SPDIF_MPEG2_L23;
			default:             r.burst_type = mahd_pkg::SPDIF_NONE;
		endcase
		return r;
	endfunction

	task automatic note_failure(input string msg);
		n_fail++;
		if (n_fail <= MAX_REPORTS)
			$display("%0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got, want);
		if (got !== want)
			note_failure($sformatf("%s: expected %0d, got %0d", name, want, got));
	endtask

	// offer one candidate, starting and ending at a falling edge
	task automatic offer_header(input logic [7:0] b0, b1, b2, b3, input bit pinned,
			input hdr_fields_t pinned_want, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		byte0    <= b0;
		byte1    <= b1;
		byte2    <= b2;
		byte3    <= b3;
		do @(posedge clk); while (!in_ready);
		pending_hdrs.push_back(pinned ? pinned_want : decode_header(b0, b1, b2, b3));
		@(negedge clk);
	endtask

	// candidate source: directed table, then random headers
	initial begin : header_source
		logic [7:0] sync;
		logic [7:0] hi;
		logic [7:0] mid;
		logic [7:0] lo;
		logic [1:0] vcode;
		logic [1:0] lcode;
		logic [3:0] bri;
		logic [1:0] sfi;
		bit         swapped;
		int         pick;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		byte0    = 8'h00;
		byte1    = 8'h00;
		byte2    = 8'h00;
		byte3    = 8'h00;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_DIRECTED; i++)
			offer_header(DIRECTED_ROWS[i].b0, DIRECTED_ROWS[i].b1, DIRECTED_ROWS[i].b2,
				DIRECTED_ROWS[i].b3, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].want, 1'b0);

		for (int n = 0; n < N_RANDOM; n++) begin
			pick    = $urandom_range(0, 99);
			swapped = $urandom_range(0, 3) == 0;
			sync    = mahd_pkg::SYNC_BYTE;
			// well-formed fields first; swapped form has no mpeg2.5
			if (swapped)
				vcode = {1'b1, 1'($urandom_range(0, 1))};
			else
				do vcode = 2'($urandom); while (vcode == RAW_VER_RES);
			do lcode = 2'($urandom); while (lcode == RAW_LAY_NONE);
			bri = 4'($urandom_range(0, 14));
			sfi = 2'($urandom_range(0, 2));
			// break one field on some headers
			if (pick >= 70 && pick < 85) begin
				case ($urandom_range(0, 4))
					0: lcode = RAW_LAY_NONE;
					1: bri = RAW_BRI_BAD;
					2: sfi = RAW_SFI_BAD;
					3: vcode = swapped ? 2'($urandom_range(0, 1)) : RAW_VER_RES;
					default: sync = 8'($urandom_range(0, 254));
				endcase
			end
			hi  = {3'b111, vcode, lcode, 1'($urandom)};
			mid = {bri, sfi, 2'($urandom)};
			lo  = 8'($urandom);
			if (pick >= 85) begin
				// raw noise
				offer_header(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
					1'b0, NO_SYNC, (n / 80) % 4 == 2);
			end else if (swapped) begin
				offer_header(hi, sync, lo, mid, 1'b0, NO_SYNC, (n / 80) % 4 == 2);
			end else begin
				offer_header(sync, hi, mid, lo, 1'b0, NO_SYNC, (n / 80) % 4 == 2);
			end
		end
		in_valid <= 1'b0;

		// wait for the pipeline to empty, then watch for stray transfers
		while (pending_hdrs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_fail == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// result sink: random stalls, bursts without stalls, one long hold-off
	initial begin : result_sink
		int  n_taken;
		int  stall;
		bit  held_off;
		n_taken   = 0;
		held_off  = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			// long hold-off so the pipeline fills and drops in_ready
			if (!held_off && n_taken == HOLD_AT) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			stall = ((n_taken / 96) % 3 == 1) ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			n_taken++;
			@(negedge clk);
		end
	end

	// compare each output transfer with the oldest pending decode
	always @(posedge clk) begin : result_check
		hdr_fields_t got;
		hdr_fields_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{valid_res, stream_kind, mpeg_version, layer_number, bitrate_kbps,
				rate_hz, frame_bytes, samples_per_frame, is_mono, burst_type};
			if (pending_hdrs.size() == 0) begin
				note_failure("output transfer with no header pending");
			end else begin
				want = pending_hdrs.pop_front();
				check_field("valid_res", got.valid_res, want.valid_res);
				check_field("stream_kind", got.stream_kind, want.stream_kind);
				check_field("mpeg_version", got.mpeg_version, want.mpeg_version);
				check_field("layer_number", got.layer_number, want.layer_number);
				check_field("bitrate_kbps", got.bitrate_kbps, want.bitrate_kbps);
				check_field("rate_hz", got.rate_hz, want.rate_hz);
				check_field("frame_bytes", got.frame_bytes, want.frame_bytes);
				check_field("samples_per_frame", got.samples_per_frame,
					want.samples_per_frame);
				check_field("is_mono", got.is_mono, want.is_mono);
				check_field("burst_type", got.burst_type, want.burst_type);
			end
		end
	end

	// hang guard
	initial begin : watchdog
		#(LIMIT_NS);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== mpeg_audio_header_decoder.f =====
rtl/core/mahd_pkg.sv
rtl/core/mpeg_audio_header_decoder.sv
bench/tb_mpeg_audio_header_decoder.sv
